// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the execute unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPL(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) \
    else $error("assertion failed");

`endif

// ===== rtl/mseu_pkg.sv =====
// ----------------------------------------------------------------------------
// MIPS subset execute unit package
// Sizes, instruction codes, state and command types.
// ----------------------------------------------------------------------------
package mseu_pkg;

  localparam int unsigned MEM_BYTES = 4096;
  localparam int unsigned MEM_AW    = $clog2(MEM_BYTES);
  localparam int unsigned REG_N     = 32;

  localparam logic [5:0] OPC_SPECIAL = 6'h00;
  localparam logic [5:0] OPC_J       = 6'h02;
  localparam logic [5:0] OPC_JAL     = 6'h03;
  localparam logic [5:0] OPC_BEQ     = 6'h04;
  localparam logic [5:0] OPC_BNE     = 6'h05;
  localparam logic [5:0] OPC_ADDI    = 6'h08;
  localparam logic [5:0] OPC_ADDIU   = 6'h09;
  localparam logic [5:0] OPC_SLTI    = 6'h0A;
  localparam logic [5:0] OPC_SLTIU   = 6'h0B;
  localparam logic [5:0] OPC_ANDI    = 6'h0C;
  localparam logic [5:0] OPC_ORI     = 6'h0D;
  localparam logic [5:0] OPC_XORI    = 6'h0E;
  localparam logic [5:0] OPC_LUI     = 6'h0F;
  localparam logic [5:0] OPC_LB      = 6'h20;
  localparam logic [5:0] OPC_LH      = 6'h21;
  localparam logic [5:0] OPC_LW      = 6'h23;
  localparam logic [5:0] OPC_LBU     = 6'h24;
  localparam logic [5:0] OPC_LHU     = 6'h25;
  localparam logic [5:0] OPC_SB      = 6'h28;
  localparam logic [5:0] OPC_SH      = 6'h29;
  localparam logic [5:0] OPC_SW      = 6'h2B;

  localparam logic [5:0] FN_SLL   = 6'h00;
  localparam logic [5:0] FN_SRL   = 6'h02;
  localparam logic [5:0] FN_SRA   = 6'h03;
  localparam logic [5:0] FN_JR    = 6'h08;
  localparam logic [5:0] FN_MFHI  = 6'h10;
  localparam logic [5:0] FN_MFLO  = 6'h12;
  localparam logic [5:0] FN_MULT  = 6'h18;
  localparam logic [5:0] FN_MULTU = 6'h19;
  localparam logic [5:0] FN_DIV   = 6'h1A;
  localparam logic [5:0] FN_DIVU  = 6'h1B;
  localparam logic [5:0] FN_ADD   = 6'h20;
  localparam logic [5:0] FN_SUB   = 6'h22;
  localparam logic [5:0] FN_AND   = 6'h24;
  localparam logic [5:0] FN_OR    = 6'h25;
  localparam logic [5:0] FN_XOR   = 6'h26;
  localparam logic [5:0] FN_NOR   = 6'h27;

  typedef enum logic [2:0] {
    K_SIMPLE,
    K_MUL,
    K_DIV,
    K_LOAD,
    K_STORE
  } mseu_kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_MUL,
    ST_DIV,
    ST_DIV_FIX,
    ST_LD_ADDR,
    ST_LD_CAP,
    ST_ST_WR,
    ST_DONE
  } mseu_state_t;

  typedef struct packed {
    logic in_ready;
    logic exec;
    logic mul_done;
    logic div_step;
    logic div_fix;
    logic mem_wr;
    logic ld_cap;
    logic commit;
  } mseu_cmd_t;

  typedef struct packed {
    logic       in_valid;
    mseu_kind_t kind;
    logic       mem_last;
    logic       div_last;
    logic       out_free;
  } mseu_sts_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage

// ===== rtl/mseu_if.sv =====
// ----------------------------------------------------------------------------
// Execute unit channels
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mseu_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] instruction;
  logic [31:0] current_pc;
  logic [11:0] preload_address;
  logic [31:0] preload_word;

  modport source (output valid, op, instruction, current_pc, preload_address,
                  preload_word, input ready);
  modport sink (input valid, op, instruction, current_pc, preload_address,
                preload_word, output ready);
endinterface

interface mseu_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic        reg_written;
  logic [4:0]  reg_index;
  logic [31:0] reg_value;
  logic        hilo_written;
  logic [31:0] hi_value;
  logic [31:0] lo_value;
  logic [2:0]  store_bytes;
  logic [11:0] store_address;
  logic [31:0] store_value;
  logic        unimplemented;

  modport source (output valid, next_pc, reg_written, reg_index, reg_value,
                  hilo_written, hi_value, lo_value, store_bytes, store_address,
                  store_value, unimplemented, input ready);
  modport sink (input valid, next_pc, reg_written, reg_index, reg_value,
                hilo_written, hi_value, lo_value, store_bytes, store_address,
                store_value, unimplemented, output ready);
endinterface

// ===== rtl/mseu_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mseu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r <= mem[raddr];
  end

  assign rdata = rd_r;

endmodule

// ===== rtl/mseu_ctrl.sv =====
// ----------------------------------------------------------------------------
// Execute unit controller
// Sequences read, execute, multiply, divide, memory and commit steps.
// ----------------------------------------------------------------------------
module mseu_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  mseu_pkg::mseu_sts_t sts,
  output mseu_pkg::mseu_cmd_t cmd
);
  import mseu_pkg::*;

  mseu_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (sts.in_valid) state_nxt = ST_READ;
      end
      ST_READ: state_nxt = ST_EXEC;
      ST_EXEC: begin
        case (sts.kind)
          K_MUL:   state_nxt = ST_MUL;
          K_DIV:   state_nxt = ST_DIV;
          K_LOAD:  state_nxt = ST_LD_ADDR;
          K_STORE: state_nxt = ST_ST_WR;
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_MUL: state_nxt = ST_DONE;
      ST_DIV: begin
        if (sts.div_last) state_nxt = ST_DIV_FIX;
      end
      ST_DIV_FIX: state_nxt = ST_DONE;
      ST_LD_ADDR: state_nxt = ST_LD_CAP;
      ST_LD_CAP: state_nxt = sts.mem_last ? ST_DONE : ST_LD_ADDR;
      ST_ST_WR: begin
        if (sts.mem_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE:    cmd.in_ready = rst_n;
      ST_EXEC:    cmd.exec     = 1'b1;
      ST_MUL:     cmd.mul_done = 1'b1;
      ST_DIV:     cmd.div_step = 1'b1;
      ST_DIV_FIX: cmd.div_fix  = 1'b1;
      ST_LD_CAP:  cmd.ld_cap   = 1'b1;
      ST_ST_WR:   cmd.mem_wr   = 1'b1;
      ST_DONE:    cmd.commit   = sts.out_free;
      default:    cmd = '0;
    endcase
  end

endmodule

// ===== rtl/mseu_dp.sv =====
// ----------------------------------------------------------------------------
// Execute unit datapath
// Register file, HI/LO, data memory, ALU, multiplier, divider, result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mseu_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  mseu_pkg::mseu_cmd_t cmd,
  output mseu_pkg::mseu_sts_t sts,
  mseu_in_if.sink             in_ch,
  mseu_out_if.source          out_ch
);
  import mseu_pkg::*;

  logic              op_r;
  logic [31:0]       ins_r, pc_r, plw_r;
  logic [11:0]       pla_r;

  logic [5:0]        opc, fn;
  logic [4:0]        rs, rt, rd, sh;
  logic [15:0]       imm;
  logic [31:0]       rs_q, rt_q, a, b, ea;
  logic [REG_N-1:0]  rf_vld_r;
  logic              rf_we;
  logic [31:0]       hi_r, lo_r;
  mseu_kind_t        kind;

  logic [31:0]       e_next, e_val, e_sv;
  logic              e_wr, e_bad;
  logic [4:0]        e_idx;
  logic [2:0]        e_sb, e_mn;
  logic [11:0]       e_sa;
  logic [MEM_AW-1:0] e_mbase;
  logic [31:0]       e_mword;

  logic [31:0]       next_r, wr_val_r, hv_r, lv_r, sv_r;
  logic              wr_r, hl_r, bad_r;
  logic [4:0]        wr_idx_r;
  logic [2:0]        sb_r, mn_r;
  logic [11:0]       sa_r;

  logic [MEM_AW-1:0] mbase_r, maddr;
  logic [31:0]       mword_r, ldw_r, ldw_nxt, ld_fmt;
  logic [1:0]        k_r;
  logic [2:0]        k_ext;
  logic [7:0]        mem_q;

  logic              ms;
  logic signed [65:0] prod;
  logic [63:0]       prod_r;

  logic              dsg, an, bn;
  logic [31:0]       a_r, quo_r, rem_r, dvs_r, quo_nxt, rem_nxt;
  logic              an_r, qneg_r, bz_r;
  logic [4:0]        div_cnt_r;
  logic [32:0]       rem_sh, diff;

  logic              out_vld_r;

  assign opc = ins_r[31:26];
  assign rs  = ins_r[25:21];
  assign rt  = ins_r[20:16];
  assign rd  = ins_r[15:11];
  assign sh  = ins_r[10:6];
  assign fn  = ins_r[5:0];
  assign imm = ins_r[15:0];

  assign a  = rf_vld_r[rs] ? rs_q : '0;
  assign b  = rf_vld_r[rt] ? rt_q : '0;
  assign ea = a + sx16(imm);

  assign rf_we = cmd.commit && wr_r;

  mseu_ram #(.WIDTH(32), .DEPTH(REG_N)) u_rf_rs (
    .clk(clk), .we(rf_we), .waddr(wr_idx_r), .wdata(wr_val_r),
    .raddr(rs), .rdata(rs_q)
  );

  mseu_ram #(.WIDTH(32), .DEPTH(REG_N)) u_rf_rt (
    .clk(clk), .we(rf_we), .waddr(wr_idx_r), .wdata(wr_val_r),
    .raddr(rt), .rdata(rt_q)
  );

  assign maddr = mbase_r + MEM_AW'(k_r);

  mseu_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_dmem (
    .clk(clk), .we(cmd.mem_wr), .waddr(maddr), .wdata(mword_r[8*k_r +: 8]),
    .raddr(maddr), .rdata(mem_q)
  );

  always_comb begin
    kind = K_SIMPLE;
    if (op_r) begin
      kind = K_STORE;
    end else begin
      case (opc)
        OPC_SPECIAL: begin
          if (fn == FN_MULT || fn == FN_MULTU) kind = K_MUL;
          else if (fn == FN_DIV || fn == FN_DIVU) kind = K_DIV;
        end
        OPC_LB, OPC_LH, OPC_LW, OPC_LBU, OPC_LHU: kind = K_LOAD;
        OPC_SB, OPC_SH, OPC_SW: kind = K_STORE;
        default: kind = K_SIMPLE;
      endcase
    end
  end

  always_comb begin
    e_next  = pc_r;
    e_wr    = 1'b0;
    e_idx   = '0;
    e_val   = '0;
    e_bad   = 1'b0;
    e_sb    = '0;
    e_sa    = '0;
    e_sv    = '0;
    e_mn    = '0;
    e_mbase = MEM_AW'(ea);
    e_mword = b;
    if (op_r) begin
      e_mn    = 3'd4;
      e_mbase = MEM_AW'(pla_r);
      e_mword = plw_r;
    end else begin
      case (opc)
        OPC_SPECIAL: begin
          e_wr  = 1'b1;
          e_idx = rd;
          case (fn)
            FN_ADD:  e_val = a + b;
            FN_SUB:  e_val = a - b;
            FN_AND:  e_val = a & b;
            FN_OR:   e_val = a | b;
            FN_XOR:  e_val = a ^ b;
            FN_NOR:  e_val = ~(a | b);
            FN_SLL:  e_val = b << sh;
            FN_SRL:  e_val = b >> sh;
            FN_SRA:  e_val = $unsigned($signed(b) >>> sh);
            FN_MFHI: e_val = hi_r;
            FN_MFLO: e_val = lo_r;
            FN_JR: begin
              e_wr   = 1'b0;
              e_next = a;
            end
            FN_MULT, FN_MULTU, FN_DIV, FN_DIVU: e_wr = 1'b0;
            default: begin
              e_wr  = 1'b0;
              e_bad = 1'b1;
            end
          endcase
        end
        OPC_J: e_next = {pc_r[31:28], ins_r[25:0], 2'b00};
        OPC_JAL: begin
          e_next = {pc_r[31:28], ins_r[25:0], 2'b00};
          e_wr   = 1'b1;
          e_idx  = 5'd31;
          e_val  = pc_r;
        end
        OPC_BEQ, OPC_BNE: begin
          if ((a == b) == (opc == OPC_BEQ)) e_next = pc_r + {{14{imm[15]}}, imm, 2'b00};
        end
        OPC_ADDI, OPC_ADDIU: begin
          e_wr = 1'b1; e_idx = rt; e_val = ea;
        end
        OPC_ANDI: begin
          e_wr = 1'b1; e_idx = rt; e_val = a & {16'h0000, imm};
        end
        OPC_ORI: begin
          e_wr = 1'b1; e_idx = rt; e_val = a | {16'h0000, imm};
        end
        OPC_XORI: begin
          e_wr = 1'b1; e_idx = rt; e_val = a ^ {16'h0000, imm};
        end
        OPC_SLTI: begin
          e_wr = 1'b1; e_idx = rt;
          e_val = {31'd0, $signed(a) < $signed(sx16(imm))};
        end
        OPC_SLTIU: begin
          e_wr = 1'b1; e_idx = rt; e_val = {31'd0, a < sx16(imm)};
        end
        OPC_LUI: begin
          e_wr = 1'b1; e_idx = rt; e_val = {imm, 16'h0000};
        end
        OPC_LW: begin
          e_wr = 1'b1; e_idx = rt; e_mn = 3'd4;
        end
        OPC_LH, OPC_LHU: begin
          e_wr = 1'b1; e_idx = rt; e_mn = 3'd2;
        end
        OPC_LB, OPC_LBU: begin
          e_wr = 1'b1; e_idx = rt; e_mn = 3'd1;
        end
        OPC_SW: begin
          e_mn = 3'd4; e_sb = 3'd4; e_sa = 12'(MEM_AW'(ea)); e_sv = b;
        end
        OPC_SH: begin
          e_mn = 3'd2; e_sb = 3'd2; e_sa = 12'(MEM_AW'(ea)); e_sv = {16'h0000, b[15:0]};
        end
        OPC_SB: begin
          e_mn = 3'd1; e_sb = 3'd1; e_sa = 12'(MEM_AW'(ea)); e_sv = {24'h000000, b[7:0]};
        end
        default: e_bad = 1'b1;
      endcase
    end
    if (e_wr && e_idx == '0) e_wr = 1'b0;
    if (!e_wr) begin
      e_idx = '0;
      e_val = '0;
    end
  end

  assign ms   = (fn == FN_MULT);
  assign prod = $signed({ms & a[31], a}) * $signed({ms & b[31], b});

  assign dsg = (fn == FN_DIV);
  assign an  = dsg & a[31];
  assign bn  = dsg & b[31];

  assign rem_sh = {rem_r, quo_r[31]};
  assign diff   = rem_sh - {1'b0, dvs_r};

  always_comb begin
    if (!diff[32]) begin
      rem_nxt = diff[31:0];
      quo_nxt = {quo_r[30:0], 1'b1};
    end else begin
      rem_nxt = rem_sh[31:0];
      quo_nxt = {quo_r[30:0], 1'b0};
    end
  end

  always_comb begin
    ldw_nxt = ldw_r;
    ldw_nxt[8*k_r +: 8] = mem_q;
    case (opc)
      OPC_LH:  ld_fmt = sx16(ldw_nxt[15:0]);
      OPC_LHU: ld_fmt = {16'h0000, ldw_nxt[15:0]};
      OPC_LB:  ld_fmt = {{24{ldw_nxt[7]}}, ldw_nxt[7:0]};
      OPC_LBU: ld_fmt = {24'h000000, ldw_nxt[7:0]};
      default: ld_fmt = ldw_nxt;
    endcase
  end

  assign k_ext = {1'b0, k_r};

  always_ff @(posedge clk) begin
    if (in_ch.valid && cmd.in_ready) begin
      op_r  <= in_ch.op;
      ins_r <= in_ch.instruction;
      pc_r  <= in_ch.current_pc;
      pla_r <= in_ch.preload_address;
      plw_r <= in_ch.preload_word;
    end
    if (cmd.exec) begin
      next_r   <= e_next;
      wr_r     <= e_wr;
      wr_idx_r <= e_idx;
      wr_val_r <= e_val;
      bad_r    <= e_bad;
      sb_r     <= e_sb;
      sa_r     <= e_sa;
      sv_r     <= e_sv;
      mn_r     <= e_mn;
      mbase_r  <= e_mbase;
      mword_r  <= e_mword;
      k_r      <= '0;
      ldw_r    <= '0;
      hl_r     <= (kind == K_MUL) || (kind == K_DIV);
      hv_r     <= '0;
      lv_r     <= '0;
      prod_r   <= prod[63:0];
      a_r      <= a;
      an_r     <= an;
      qneg_r   <= an ^ bn;
      bz_r     <= (b == '0);
      quo_r    <= an ? -a : a;
      dvs_r    <= bn ? -b : b;
      rem_r    <= '0;
      div_cnt_r <= '0;
    end
    if (cmd.mul_done) begin
      hv_r <= prod_r[63:32];
      lv_r <= prod_r[31:0];
    end
    if (cmd.div_step) begin
      quo_r     <= quo_nxt;
      rem_r     <= rem_nxt;
      div_cnt_r <= div_cnt_r + 5'd1;
    end
    if (cmd.div_fix) begin
      if (bz_r) begin
        lv_r <= '1;
        hv_r <= a_r;
      end else begin
        lv_r <= qneg_r ? -quo_r : quo_r;
        hv_r <= an_r ? -rem_r : rem_r;
      end
    end
    if (cmd.ld_cap) begin
      ldw_r <= ldw_nxt;
      k_r   <= k_r + 2'd1;
      if (wr_r) wr_val_r <= ld_fmt;
    end
    if (cmd.mem_wr) begin
      k_r <= k_r + 2'd1;
    end
    if (cmd.commit) begin
      out_ch.next_pc       <= next_r;
      out_ch.reg_written   <= wr_r;
      out_ch.reg_index     <= wr_idx_r;
      out_ch.reg_value     <= wr_val_r;
      out_ch.hilo_written  <= hl_r;
      out_ch.hi_value      <= hv_r;
      out_ch.lo_value      <= lv_r;
      out_ch.store_bytes   <= sb_r;
      out_ch.store_address <= sa_r;
      out_ch.store_value   <= sv_r;
      out_ch.unimplemented <= bad_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r  <= '0;
      hi_r      <= '0;
      lo_r      <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (rf_we) rf_vld_r[wr_idx_r] <= 1'b1;
      if (cmd.commit && hl_r) begin
        hi_r <= hv_r;
        lo_r <= lv_r;
      end
      if (cmd.commit) out_vld_r <= 1'b1;
      else if (out_ch.ready) out_vld_r <= 1'b0;
    end
  end

  assign in_ch.ready  = cmd.in_ready;
  assign out_ch.valid = out_vld_r;

  assign sts.in_valid = in_ch.valid;
  assign sts.kind     = kind;
  assign sts.mem_last = (k_ext == (mn_r - 3'd1));
  assign sts.div_last = (div_cnt_r == 5'd31);
  assign sts.out_free = !out_vld_r || out_ch.ready;

  `ASSERT_IMPL(a_rf_no_zero, clk, rst_n, rf_we |-> (wr_idx_r != 5'd0))
  `ASSERT_IMPL(a_mem_in_range, clk, rst_n, cmd.mem_wr |-> (k_ext < mn_r))
  `ASSERT_NEXT(a_commit_shows, clk, rst_n, cmd.commit, out_vld_r)

endmodule

// ===== rtl/mips_subset_execute_unit_top.sv =====
// ----------------------------------------------------------------------------
// MIPS subset execute unit
// A request passes the read and execute states, then multiply; divide (one
// quotient bit a cycle) and fix-up; an address and a capture state per load
// byte; or a write per store or preload byte (one memory byte a cycle); then
// done, which commits. A new request is taken in the cycle after the commit.
// Reset clears the register file, HI and LO; data memory is not initialised.
// ----------------------------------------------------------------------------
module mips_subset_execute_unit_top (
  input  logic       clk,
  input  logic       rst_n,
  mseu_in_if.sink    in_ch,
  mseu_out_if.source out_ch
);
  import mseu_pkg::*;

  mseu_cmd_t cmd;
  mseu_sts_t sts;

  mseu_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .sts(sts), .cmd(cmd)
  );

  mseu_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_ch(in_ch), .out_ch(out_ch)
  );

endmodule
